// ===== sv/cpt_pkg.sv =====
// shared types and constants for the cascaded prescaled timer block
// no dependencies; imported by every module of the block
package cpt_pkg;

  localparam int NUM_TIMERS  = 4;
  localparam int COUNT_WIDTH = 16;
  localparam int CYC_W       = 11;
  localparam int NUM_PRESC   = 4;
  localparam int IRQ_W       = 4;
  localparam int RD_W        = 24;

  // register layout bit positions
  localparam int RLD_LO   = 0;
  localparam int RLD_HI   = 15;
  localparam int CTL_LO   = 16;
  localparam int CTL_HI   = 23;
  localparam int PSEL_LO  = 16;
  localparam int CASC_BIT = 18;
  localparam int IRQ_BIT  = 22;
  localparam int EN_BIT   = 23;

  // low cycle-count bits that must be zero for each prescale choice (1, 7, 9, 11 bits)
  localparam logic [CYC_W-1:0] PRESC_MASK [NUM_PRESC] = '{
    11'h001, 11'h07f, 11'h1ff, 11'h7ff
  };

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } cpt_kind_t;

  // per-cell command for one accepted transfer
  typedef struct packed {
    logic tick;
    logic wr;
    logic wr_rld;
    logic wr_ctl;
  } cpt_cmd_t;

  // per-cell status as seen by a register read
  typedef struct packed {
    logic [15:0] cnt;
    logic [1:0]  psel;
    logic        casc;
    logic        irq_en;
    logic        run;
  } cpt_stat_t;

endpackage

// ===== sv/cpt_prescaler.sv =====
// cycle counter advanced by each tick, and prescale strobes
// depends on cpt_pkg
module cpt_prescaler
  import cpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick,
  output logic [NUM_PRESC-1:0] strb
);

  logic [CYC_W-1:0] cyc_r;
  logic [CYC_W-1:0] cyc_nxt;

  assign cyc_nxt = cyc_r + CYC_W'(1);

  // strobes look at the advanced count, qualified by the tick
  always_comb begin
    for (int k = 0; k < NUM_PRESC; k++) begin
      strb[k] = tick && ((cyc_nxt & PRESC_MASK[k]) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyc_r <= '0;
    end else if (tick) begin
      cyc_r <= cyc_nxt;
    end
  end

endmodule

// ===== sv/cpt_cell.sv =====
// one timer cell: count, reload and control bits, overflow to the next cell
// depends on cpt_pkg
module cpt_cell
  import cpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpt_cmd_t             cmd,
  input  logic [31:0]          data,
  input  logic [31:0]          mask,
  input  logic [NUM_PRESC-1:0] strb,
  input  logic                 ovf_in,
  output logic                 ovf_out,
  output logic                 irq,
  output cpt_stat_t            stat
);

  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] rld_r, rld_nxt;
  logic [1:0]             psel_r, psel_nxt;
  logic                   casc_r, casc_nxt;
  logic                   irq_en_r, irq_en_nxt;
  logic                   run_r, run_nxt;
  logic [COUNT_WIDTH-1:0] wmask;
  logic                   step;

  assign wmask = COUNT_WIDTH'(mask[RLD_HI:RLD_LO]);

  assign step    = cmd.tick && run_r && (casc_r ? ovf_in : strb[psel_r]);
  assign ovf_out = step && (cnt_r == '1);
  assign irq     = ovf_out && irq_en_r;

  always_comb begin
    rld_nxt    = rld_r;
    cnt_nxt    = cnt_r;
    psel_nxt   = psel_r;
    casc_nxt   = casc_r;
    irq_en_nxt = irq_en_r;
    run_nxt    = run_r;
    if (cmd.wr && cmd.wr_rld) begin
      rld_nxt = (rld_r & ~wmask) | (COUNT_WIDTH'(data[RLD_HI:RLD_LO]) & wmask);
    end
    if (cmd.wr && cmd.wr_ctl) begin
      // starting a stopped timer loads the freshly written reload
      if (!run_r && data[EN_BIT]) begin
        cnt_nxt = rld_nxt;
      end
      psel_nxt   = data[PSEL_LO+1:PSEL_LO];
      casc_nxt   = data[CASC_BIT];
      irq_en_nxt = data[IRQ_BIT];
      run_nxt    = data[EN_BIT];
    end
    if (step) begin
      cnt_nxt = ovf_out ? rld_r : cnt_r + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rld_r    <= '0;
      psel_r   <= '0;
      casc_r   <= 1'b0;
      irq_en_r <= 1'b0;
      run_r    <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rld_r    <= rld_nxt;
      psel_r   <= psel_nxt;
      casc_r   <= casc_nxt;
      irq_en_r <= irq_en_nxt;
      run_r    <= run_nxt;
    end
  end

  assign stat.cnt    = 16'(cnt_r);
  assign stat.psel   = psel_r;
  assign stat.casc   = casc_r;
  assign stat.irq_en = irq_en_r;
  assign stat.run    = run_r;

endmodule

// ===== sv/cascaded_prescaled_timer_quad.sv =====
// top level of the cascaded prescaled timer block
// depends on cpt_pkg, cpt_prescaler and cpt_cell
//
// Four 16-bit up-counting timers sharing one 11-bit prescaler. Every input
// transfer is a clock tick, a masked register write or a register read, and
// every one produces exactly one result transfer in the next cycle: read data
// for a read, the per-timer interrupt pulses for a tick, zeros otherwise.
// The block takes one transfer per cycle; a result sits in the output
// register and the input stalls only while that register is full and the
// output side stalls. The timers form a row of cells where each overflow
// feeds the next cell inside the same tick, so a cascade chain ripples fully
// within that tick, combinationally through all four cells. There is no
// clearing pass: reset clears all state but the output data registers.
module cascaded_prescaled_timer_quad
  import cpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_kind,
  input  logic [1:0]       in_timer_select,
  input  logic [31:0]      in_write_data,
  input  logic [31:0]      in_write_mask,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [RD_W-1:0]  out_read_data,
  output logic [IRQ_W-1:0] out_irq_pulses
);

  logic             out_valid_r;
  logic [RD_W-1:0]  rd_r, rd_nxt;
  logic [IRQ_W-1:0] irq_r, irq_nxt;

  // handshake: input moves whenever the output register can take a result
  logic in_xfer;
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // decode of the transfer kind
  logic is_tick, is_wr, is_rd;
  always_comb begin
    is_tick = 1'b0;
    is_wr   = 1'b0;
    is_rd   = 1'b0;
    unique case (in_kind)
      KIND_TICK:  is_tick = in_xfer;
      KIND_WRITE: is_wr   = in_xfer;
      KIND_READ:  is_rd   = in_xfer;
      default: ;  // unused kind: no effect, zero result
    endcase
  end

  // shared prescaler
  logic [NUM_PRESC-1:0] strb;
  cpt_prescaler u_presc (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (is_tick),
    .strb  (strb)
  );

  // row of timer cells with the overflow chain between neighbors
  logic      ovf     [NUM_TIMERS+1];
  logic      cell_irq[NUM_TIMERS];
  logic      hit     [NUM_TIMERS];
  cpt_cmd_t  cmd     [NUM_TIMERS];
  cpt_stat_t stat    [NUM_TIMERS];

  // timer zero has no lower neighbor, so in cascade mode it never counts
  assign ovf[0] = 1'b0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    assign hit[i]        = (32'(in_timer_select) == 32'(i));
    assign cmd[i].tick   = is_tick;
    assign cmd[i].wr     = is_wr && hit[i];
    assign cmd[i].wr_rld = |in_write_mask[RLD_HI:RLD_LO];
    assign cmd[i].wr_ctl = |in_write_mask[CTL_HI:CTL_LO];

    cpt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd[i]),
      .data    (in_write_data),
      .mask    (in_write_mask),
      .strb    (strb),
      .ovf_in  (ovf[i]),
      .ovf_out (ovf[i+1]),
      .irq     (cell_irq[i]),
      .stat    (stat[i])
    );
  end

  // result: read mux over the cells, irq gather for ticks
  always_comb begin
    rd_nxt  = '0;
    irq_nxt = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (is_rd && hit[i]) begin
        rd_nxt[RLD_HI:RLD_LO]      = stat[i].cnt;
        rd_nxt[PSEL_LO+1:PSEL_LO]  = stat[i].psel;
        rd_nxt[CASC_BIT]           = stat[i].casc;
        rd_nxt[IRQ_BIT]            = stat[i].irq_en;
        rd_nxt[EN_BIT]             = stat[i].run;
      end
      if (i < IRQ_W) begin
        irq_nxt[i % IRQ_W] = cell_irq[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_r  <= rd_nxt;
      irq_r <= irq_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = rd_r;
  assign out_irq_pulses = irq_r;

`ifndef NO_ASSERTIONS
  // a read and a tick never share a result
  a_rd_irq_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_irq_pulses != '0) |-> (out_read_data == '0))
    else $error("read data and irq pulses in one result");

  // an accepted transfer always leaves a result behind
  a_xfer_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid)
    else $error("accepted transfer lost its result");

  // a non-tick transfer never reports an interrupt
  a_irq_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !is_tick |=> (out_irq_pulses == '0))
    else $error("irq pulse without a tick");
`endif

endmodule
